FILE: rtl/core/ssc_pkg.sv
// Shared types and constants for the subset-sum coverage checker.
`timescale 1ns / 1ps

package ssc_pkg;

  localparam int unsigned ElemW   = 7;
  localparam int unsigned ElemMax = 127;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SHIFT,
    S_CHECK,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    SRC_MEM,
    SRC_SEED,
    SRC_ZERO
  } src_kind_e;

endpackage

FILE: rtl/core/ssc_if.sv
// Valid/ready channel interfaces for elements in and coverage results out.
`timescale 1ns / 1ps

interface ssc_in_if;
  logic                        valid;
  logic                        ready;
  logic [ssc_pkg::ElemW-1:0]   element_value;
  logic                        last_element;

  modport source (output valid, element_value, last_element, input ready);
  modport sink   (input valid, element_value, last_element, output ready);
endinterface

interface ssc_out_if;
  logic valid;
  logic ready;
  logic set_passes;
  logic sum_overflow;

  modport source (output valid, set_passes, sum_overflow, input ready);
  modport sink   (input valid, set_passes, sum_overflow, output ready);
endinterface

FILE: rtl/core/ssc_mem.sv
// Bitset word store: one write port, two registered read ports.
`timescale 1ns / 1ps

module ssc_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: rtl/core/ssc_word_unit.sv
// Per-word datapath: shifted OR update and range coverage test.
`timescale 1ns / 1ps

module ssc_word_unit #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned RW        = 6,
  parameter int unsigned RelW      = 13
) (
  input  logic [WORD_BITS-1:0]   old_word_i,
  input  logic [WORD_BITS-1:0]   src_hi_i,
  input  logic [WORD_BITS-1:0]   src_lo_i,
  input  logic [RW-1:0]          shift_i,
  input  logic signed [RelW-1:0] lo_rel_i,
  input  logic signed [RelW-1:0] hi_rel_i,
  output logic [WORD_BITS-1:0]   new_word_o,
  output logic                   covered_o
);

  logic [2*WORD_BITS-1:0] cat_shifted;
  logic [WORD_BITS-1:0]   range_mask;

  assign cat_shifted = {src_hi_i, src_lo_i} << shift_i;
  assign new_word_o  = old_word_i | cat_shifted[2*WORD_BITS-1:WORD_BITS];

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      range_mask[b] = (lo_rel_i <= RelW'(b)) && (RelW'(b) < hi_rel_i);
    end
  end

  assign covered_o = &(old_word_i | ~range_mask);

endmodule

FILE: rtl/core/subset_sum_coverage_check_core.sv
// Subset-sum coverage checker top level: sequencer, bitset store and word datapath.
`timescale 1ns / 1ps

// Elements of one ascending set arrive one per transfer; the marked last element
// closes the set and yields one result (pass or fail, with overflow flagged). The
// reachable-sum bitset lives in a memory of NumWords words of WORD_BITS bits and is
// updated one word per cycle, so a non-zero element that fits holds ready low while
// the bitset is updated; a zero or overflowing element is taken straight from idle.
// The last element adds a range walk, which also clears the bitset, then loads the
// result register, waiting while the previous result is still not taken. After
// reset the block clears the memory before it takes the first element.

module subset_sum_coverage_check_core #(
  parameter int unsigned SUM_BITS  = 1024,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssc_in_if.sink     in_i,
  ssc_out_if.source  out_o
);

  localparam int unsigned ElemW    = ssc_pkg::ElemW;
  localparam int unsigned NumWords = (SUM_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AddrW    = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int unsigned CntW     = $clog2(NumWords + 2);
  localparam int unsigned TotW     = $clog2(SUM_BITS + 1);
  localparam int unsigned SumW     = TotW + 1;
  localparam int unsigned MaxQ     = ssc_pkg::ElemMax / WORD_BITS;
  localparam int unsigned QW       = (MaxQ > 0) ? $clog2(MaxQ + 1) : 1;
  localparam int unsigned RW       = $clog2(WORD_BITS);
  localparam int unsigned IdxW     = ((CntW > QW) ? CntW : QW) + 2;
  localparam int unsigned RelW     = TotW + 2;
  localparam int unsigned TopBits  = SUM_BITS - (NumWords - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] TopMask = {WORD_BITS{1'b1}} >> (WORD_BITS - TopBits);
  localparam logic [WORD_BITS-1:0] SeedWord = {1'b1, {(WORD_BITS - 1){1'b0}}};

  ssc_pkg::state_e state_q, state_d;

  logic [CntW-1:0]        cnt_q;
  logic [TotW-1:0]        total_q;
  logic                   ovf_q;
  logic                   last_q;
  logic [ElemW-1:0]       elem_q;
  logic [RW-1:0]          r_q;
  logic [QW-1:0]          q_q;
  logic                   pass_q;
  logic [WORD_BITS-1:0]   hi_q;
  logic                   p_vld_q;
  logic                   p_prime_q;
  logic [AddrW-1:0]       p_addr_q;
  ssc_pkg::src_kind_e     p_kind_q;
  logic signed [RelW-1:0] lo_rel_q;
  logic signed [RelW-1:0] hi_rel_q;
  logic                   out_valid_q;
  logic                   out_pass_q;
  logic                   out_ovf_q;

  logic                   accept;
  logic [ElemW-1:0]       in_val;
  logic [SumW-1:0]        sum_c;
  logic                   add_ok;
  logic [QW-1:0]          q_c;
  logic [RW-1:0]          r_c;
  logic                   out_free;

  logic                   issue;
  logic                   prime;
  logic [AddrW-1:0]       raddr_a;
  logic [AddrW-1:0]       raddr_b;
  logic signed [IdxW-1:0] src_idx;
  ssc_pkg::src_kind_e     src_kind;
  logic                   we;
  logic [AddrW-1:0]       waddr;
  logic [WORD_BITS-1:0]   wdata;

  logic [WORD_BITS-1:0]   rdata_a;
  logic [WORD_BITS-1:0]   rdata_b;
  logic [WORD_BITS-1:0]   src_lo;
  logic [WORD_BITS-1:0]   new_word;
  logic                   covered;

  assign in_val   = in_i.element_value;
  assign accept   = in_i.valid && in_i.ready;
  assign sum_c    = SumW'(total_q) + SumW'(in_val);
  assign add_ok   = (in_val != '0) && (sum_c <= SumW'(SUM_BITS));
  assign out_free = !out_valid_q || out_o.ready;

  // element split into whole words and bit offset
  always_comb begin
    q_c = '0;
    r_c = RW'(in_val);
    for (int k = 0; k <= int'(MaxQ); k++) begin
      if (in_val >= ElemW'(k * WORD_BITS)) begin
        q_c = QW'(k);
        r_c = RW'(in_val - ElemW'(k * WORD_BITS));
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssc_pkg::S_INIT: begin
        if (cnt_q == CntW'(NumWords - 1)) state_d = ssc_pkg::S_IDLE;
      end
      ssc_pkg::S_IDLE: begin
        if (in_i.valid) begin
          if (add_ok) begin
            state_d = ssc_pkg::S_SHIFT;
          end else if (in_i.last_element) begin
            state_d = ssc_pkg::S_CHECK;
          end
        end
      end
      ssc_pkg::S_SHIFT: begin
        if (cnt_q == CntW'(NumWords + 1)) begin
          state_d = last_q ? ssc_pkg::S_CHECK : ssc_pkg::S_IDLE;
        end
      end
      ssc_pkg::S_CHECK: begin
        if (cnt_q == CntW'(NumWords)) state_d = ssc_pkg::S_DONE;
      end
      ssc_pkg::S_DONE: begin
        if (out_free) state_d = ssc_pkg::S_IDLE;
      end
      default: state_d = ssc_pkg::S_IDLE;
    endcase
  end

  assign src_idx = $signed(IdxW'(NumWords - 1)) - $signed(IdxW'(q_q)) - $signed(IdxW'(cnt_q));
  assign raddr_b = AddrW'(src_idx);

  always_comb begin
    if (!src_idx[IdxW-1]) begin
      src_kind = ssc_pkg::SRC_MEM;
    end else if (src_idx == '1) begin
      src_kind = ssc_pkg::SRC_SEED;
    end else begin
      src_kind = ssc_pkg::SRC_ZERO;
    end
  end

  always_comb begin
    in_i.ready = 1'b0;
    issue      = 1'b0;
    prime      = 1'b0;
    raddr_a    = AddrW'(cnt_q);
    we         = 1'b0;
    waddr      = p_addr_q;
    wdata      = '0;
    unique case (state_q)
      ssc_pkg::S_INIT: begin
        we    = 1'b1;
        waddr = AddrW'(cnt_q);
      end
      ssc_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
      end
      ssc_pkg::S_SHIFT: begin
        issue   = cnt_q <= CntW'(NumWords);
        prime   = cnt_q == '0;
        raddr_a = AddrW'(CntW'(NumWords) - cnt_q);
        we      = p_vld_q;
        wdata   = (p_addr_q == AddrW'(NumWords - 1)) ? (new_word & TopMask) : new_word;
      end
      ssc_pkg::S_CHECK: begin
        issue = cnt_q < CntW'(NumWords);
        we    = p_vld_q;
      end
      ssc_pkg::S_DONE: begin
        in_i.ready = 1'b0;
      end
      default: in_i.ready = 1'b0;
    endcase
  end

  always_comb begin
    unique case (p_kind_q)
      ssc_pkg::SRC_MEM:  src_lo = rdata_b;
      ssc_pkg::SRC_SEED: src_lo = SeedWord;
      default:           src_lo = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssc_pkg::S_INIT;
      cnt_q       <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      pass_q      <= 1'b0;
      p_vld_q     <= 1'b0;
      p_prime_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= (state_q != state_d) ? '0 : cnt_q + 1'b1;
      p_vld_q   <= issue && !prime;
      p_prime_q <= issue && prime;
      if (accept) begin
        last_q <= in_i.last_element;
        if (add_ok) begin
          total_q <= TotW'(sum_c);
        end else if (in_val != '0) begin
          ovf_q <= 1'b1;
        end
      end
      if (state_q == ssc_pkg::S_CHECK) begin
        if (cnt_q == '0) begin
          pass_q <= 1'b1;
        end else if (p_vld_q) begin
          pass_q <= pass_q & covered;
        end
      end
      if (state_q == ssc_pkg::S_DONE && out_free) begin
        out_valid_q <= 1'b1;
        total_q     <= '0;
        ovf_q       <= 1'b0;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      elem_q <= in_val;
      q_q    <= q_c;
      r_q    <= r_c;
    end
    p_addr_q <= raddr_a;
    p_kind_q <= src_kind;
    if (state_q == ssc_pkg::S_SHIFT && (p_prime_q || p_vld_q)) begin
      hi_q <= src_lo;
    end
    if (state_q == ssc_pkg::S_CHECK) begin
      if (cnt_q == '0) begin
        lo_rel_q <= $signed(RelW'(elem_q));
        hi_rel_q <= $signed(RelW'(total_q)) - $signed(RelW'(elem_q));
      end else if (p_vld_q) begin
        lo_rel_q <= lo_rel_q - $signed(RelW'(WORD_BITS));
        hi_rel_q <= hi_rel_q - $signed(RelW'(WORD_BITS));
      end
    end
    if (state_q == ssc_pkg::S_DONE && out_free) begin
      out_pass_q <= pass_q && !ovf_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.set_passes   = out_pass_q;
  assign out_o.sum_overflow = out_ovf_q;

  ssc_mem #(
    .DEPTH (NumWords),
    .WIDTH (WORD_BITS),
    .AW    (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  ssc_word_unit #(
    .WORD_BITS (WORD_BITS),
    .RW        (RW),
    .RelW      (RelW)
  ) u_word (
    .old_word_i (rdata_a),
    .src_hi_i   (hi_q),
    .src_lo_i   (src_lo),
    .shift_i    (r_q),
    .lo_rel_i   (lo_rel_q),
    .hi_rel_i   (hi_rel_q),
    .new_word_o (new_word),
    .covered_o  (covered)
  );

endmodule

FILE: verif/tb_subset_sum_coverage_check_core.sv
// Self-checking testbench for the subset-sum coverage checker core.
`timescale 1ns / 1ps

module tb_subset_sum_coverage_check_core;

  localparam int unsigned SumBits  = 1024;
  localparam int unsigned WordBits = 64;
  localparam int unsigned RandItems = 1300;

  typedef logic [ssc_pkg::ElemW-1:0] elem_t;

  typedef struct packed {
    logic passes;
    logic overflow;
  } verdict_t;

  class set_verdict_board;
    logic [SumBits-1:0] reach;
    int unsigned        total;
    bit                 overflowed;
    verdict_t           pending_verdicts[$];
    int unsigned        errors;

    function new();
      errors = 0;
      clear_set();
    endfunction

    function void clear_set();
      reach      = '0;
      total      = 0;
      overflowed = 1'b0;
    endfunction

    // Fold one accepted element into the reachable-sum set; close the set on last.
    function void take_element(elem_t v, logic last);
      verdict_t    vd;
      int unsigned hi;
      if (v != 0) begin
        if (total + v > SumBits) begin
          overflowed = 1'b1;
        end else begin
          total      += v;
          reach      = reach | (reach << v);
          reach[v-1] = 1'b1;
        end
      end
      if (!last) return;
      vd.overflow = overflowed;
      vd.passes   = !overflowed;
      if (!overflowed) begin
        hi = total - v;
        for (int unsigned i = v; i < hi; i++) begin
          if (!reach[i]) vd.passes = 1'b0;
        end
      end
      pending_verdicts = {pending_verdicts, vd};
      clear_set();
    endfunction

    function void check_verdict(logic passes, logic overflow);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual set_passes %0b sum_overflow %0b",
                 $time, passes, overflow);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (passes !== want.passes) begin
        $display("%0t: set_passes expected %0b actual %0b", $time, want.passes, passes);
        errors++;
      end
      if (overflow !== want.overflow) begin
        $display("%0t: sum_overflow expected %0b actual %0b", $time, want.overflow, overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ssc_in_if  in_if ();
  ssc_out_if out_if ();

  subset_sum_coverage_check_core #(
    .SUM_BITS (SumBits),
    .WORD_BITS(WordBits)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  set_verdict_board board;
  int unsigned      tx_idle_pct;
  int unsigned      rx_idle_pct;
  int unsigned      items_sent;
  elem_t            set_buf[$];

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Entered at a falling edge; returns at the falling edge after the transfer.
  task automatic send_element(elem_t v, logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.element_value <= v;
    in_if.last_element  <= last;
    do @(posedge clk_i); while (!in_if.ready);
    board.take_element(v, last);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_set();
    foreach (set_buf[k]) send_element(set_buf[k], k == set_buf.size() - 1);
  endtask

  task automatic build_random_set();
    int kind;
    int len;
    int val;
    kind = $urandom_range(0, 99);
    set_buf.delete();
    if (kind < 12) begin
      // noise: unordered values, zeros included
      len = $urandom_range(1, 10);
      repeat (len) set_buf = {set_buf, elem_t'($urandom_range(0, 127))};
    end else if (kind < 26) begin
      // heavy sets around the sum limit
      len = $urandom_range(7, 10);
      val = $urandom_range(90, 127);
      repeat (len) begin
        set_buf = {set_buf, elem_t'(val)};
        val = val + $urandom_range(0, 127 - val);
      end
    end else begin
      len = $urandom_range(1, 14);
      val = $urandom_range(1, 4);
      repeat (len) begin
        set_buf = {set_buf, elem_t'(val)};
        val = val + $urandom_range(0, (kind < 65) ? 3 : 15);
        if (val > 127) val = 127;
      end
    end
  endtask

  initial begin
    board               = new();
    tx_idle_pct         = 23;
    rx_idle_pct         = 78;
    items_sent          = 0;
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.element_value = '0;
    in_if.last_element  = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed sets
    set_buf = '{elem_t'(0)};
    send_set();
    set_buf = '{elem_t'(127)};
    send_set();
    set_buf = '{elem_t'(1), elem_t'(2), elem_t'(3), elem_t'(4)};
    send_set();
    set_buf = '{elem_t'(10), elem_t'(11), elem_t'(12), elem_t'(13)};
    send_set();
    set_buf = '{elem_t'(0), elem_t'(5), elem_t'(0)};
    send_set();
    set_buf = '{elem_t'(50), elem_t'(3)};
    send_set();
    set_buf.delete();
    repeat (8) set_buf = {set_buf, elem_t'(127)};
    set_buf = {set_buf, elem_t'(9)};
    send_set();

    items_sent = 0;
    while (items_sent < RandItems) begin
      if (items_sent < RandItems / 3) begin
        tx_idle_pct = 23;
        rx_idle_pct = 78;
      end else if (items_sent < 2 * RandItems / 3) begin
        tx_idle_pct = 78;
        rx_idle_pct = 23;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      build_random_set();
      send_set();
    end
    in_if.valid <= 1'b0;

    while (board.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (48) @(posedge clk_i);
    if (board.pending_verdicts.size() != 0) begin
      $display("%0t: %0d results expected, actual none", $time, board.pending_verdicts.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        board.check_verdict(out_if.set_passes, out_if.sum_overflow);
      end
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

endmodule

FILE: sim.f
rtl/core/ssc_pkg.sv
rtl/core/ssc_if.sv
rtl/core/ssc_mem.sv
rtl/core/ssc_word_unit.sv
rtl/core/subset_sum_coverage_check_core.sv
verif/tb_subset_sum_coverage_check_core.sv
